@@ hdl/heater_pid_with_rapid_heat_defines.svh @@
// Assertion macros shared by the heater PID checker.
`ifndef HEATER_PID_WITH_RAPID_HEAT_DEFINES_SVH
`define HEATER_PID_WITH_RAPID_HEAT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HPID_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heater PID check failed: %m");

// Next-cycle implication, disabled during reset.
`define HPID_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heater PID check failed: %m");

`endif

@@ hdl/hpid_pkg.sv @@
// Shared widths, constants and types of the heater PID controller.
package hpid_pkg;

  localparam int PWM_BITS_DEF = 10;

  localparam int TEMP_W     = 16;
  localparam int TIME_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int BAND_W     = 15;
  localparam int DUTY_W     = 10;
  localparam int PERIOD_W   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int ERR_W      = 17;
  localparam int DIFF_W     = 18;
  localparam int INTEG_W    = 24;
  localparam int SUM_W      = 35;
  localparam int DT_W       = 16;
  localparam int WIDE_W     = 64;
  localparam int MUL_A_W    = 45;
  localparam int MUL_B_W    = 20;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W + 1;

  localparam logic [PERIOD_W-1:0]      PERIOD_RST  = 16'd100;
  localparam logic [DT_W-1:0]          DT_MAX      = '1;
  localparam logic signed [SUM_W-1:0]  INTEG_LIMIT = 35'sd3200000;
  localparam logic signed [SUM_W-1:0]  INTEG_FLOOR = -35'sd3200000;
  localparam logic [MUL_B_W-1:0]       SCALE_K     = 20'd1000;
  localparam logic [MUL_B_W-1:0]       SCALE_M     = 20'd1000000;
  localparam logic signed [MUL_A_W-1:0] DUTY_DENOM = 45'sd409600000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_TEMP = 3'd0,
    REG_ENABLE      = 3'd1,
    REG_GAIN_P      = 3'd2,
    REG_GAIN_I      = 3'd3,
    REG_GAIN_D      = 3'd4,
    REG_BAND        = 3'd5,
    REG_RAPID_DUTY  = 3'd6,
    REG_PERIOD      = 3'd7
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PREP, ST_EVAL, ST_RAPID, ST_ED, ST_INTEG, ST_ID, ST_IG,
    ST_PE, ST_PK, ST_PD, ST_DE, ST_DK, ST_DEN, ST_CHECK, ST_DIV,
    ST_DIVEND, ST_OUT
  } ctrl_state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_CAPTURE, DP_PREP, DP_RAPID, DP_ED, DP_INTEG, DP_ID, DP_IG,
    DP_PE, DP_PK, DP_PD, DP_DE, DP_DK, DP_DEN, DP_CHECK, DP_DIV,
    DP_DIVEND, DP_OUT
  } dp_op_t;

  typedef struct packed {
    logic enable;
    logic dt_zero;
    logic rapid;
    logic acc_nonpos;
    logic acc_ge_den;
  } dp_stat_t;

endpackage

@@ hdl/heater_pid_with_rapid_heat.sv @@
// Heater PID controller with integral clamp and open-loop rapid-heat mode.
// Each input word is one temperature sample (signed, 1/16 degree F) with a
// millisecond timestamp; each enabled sample with a nonzero interval yields one
// output word carrying the PWM duty count and two flags. The error is
// target_temp minus measured_temp. When it exceeds handoff_band the block
// clears the integral and drives rapid_duty (rapid_mode set). Otherwise it runs
// one PID step: the integral (error times interval) is clamped to plus or minus
// 200 degree-seconds, with integral_limited set when the clamp acts, and the
// percent sum of the three Q8.8 gain terms is scaled into 0 to 2^PWM_BITS-1.
// Samples while disabled are dropped without effect, and a sample whose
// interval is zero only updates the stored timestamp. Sequencing: a PID
// sample runs the ten-step sequence through the one shared multiplier and
// then the restoring divider, which yields one duty bit per cycle; a PID
// sample whose duty saturates skips the divider. A finished word waits in
// the output register, so the input side keeps moving until a second
// result is ready while the first is still not taken. Configuration is a
// plain write port (cfg_we, cfg_index, cfg_data), to be used only while idle;
// the user is bound to this, as the block itself does not enforce it. Writing
// enable as zero also clears the integral, previous error and stored duty level.
module heater_pid_with_rapid_heat import hpid_pkg::*; #(
  parameter int PWM_BITS = PWM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TEMP_W-1:0]     measured_temp,
  input  logic [TIME_W-1:0]     time_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DUTY_W-1:0]     duty,
  output logic                  rapid_mode,
  output logic                  integral_limited
);

  // Command from the sequencer and status back from the datapath.
  dp_op_t   op;
  dp_stat_t stat;

  hpid_ctrl #(
    .PWM_BITS (PWM_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .op        (op)
  );

  hpid_dpath #(
    .PWM_BITS (PWM_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .measured_temp    (measured_temp),
    .time_ms          (time_ms),
    .op               (op),
    .stat             (stat),
    .duty             (duty),
    .rapid_mode       (rapid_mode),
    .integral_limited (integral_limited)
  );

endmodule

@@ hdl/hpid_dpath.sv @@
// Datapath of the heater PID controller: registers, shared multiplier, divider.
module hpid_dpath import hpid_pkg::*; #(
  parameter int PWM_BITS = PWM_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic [TEMP_W-1:0]        measured_temp,
  input  logic [TIME_W-1:0]        time_ms,
  input  dp_op_t                   op,
  output dp_stat_t                 stat,
  output logic [DUTY_W-1:0]        duty,
  output logic                     rapid_mode,
  output logic                     integral_limited
);

  localparam int EXT_W = PWM_BITS + DUTY_W;
  localparam logic [PWM_BITS-1:0] MX = '1;

  // Configuration registers.
  logic signed [TEMP_W-1:0]  target_temp;
  logic                      enable;
  logic [GAIN_W-1:0]         gain_p;
  logic [GAIN_W-1:0]         gain_i;
  logic [GAIN_W-1:0]         gain_d;
  logic [BAND_W-1:0]         handoff_band;
  logic [DUTY_W-1:0]         rapid_duty;
  logic [PERIOD_W-1:0]       default_period_ms;

  // Controller state.
  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [ERR_W-1:0]   last_error;
  logic [TIME_W-1:0]         last_time;
  logic [PWM_BITS-1:0]       duty_level;

  // Working registers.
  logic signed [TEMP_W-1:0]  meas;
  logic [TIME_W-1:0]         stamp;
  logic [DT_W-1:0]           dt;
  logic signed [ERR_W-1:0]   err;
  logic signed [WIDE_W-1:0]  prod;
  logic signed [WIDE_W-1:0]  acc;
  logic [WIDE_W-1:0]         rem;
  logic [WIDE_W-1:0]         dvs;
  logic [PWM_BITS-1:0]       quo;
  logic                      lim;
  logic                      rapid;

  logic [TIME_W-1:0]          dt_raw;
  logic [DT_W-1:0]            dt_calc;
  logic signed [ERR_W-1:0]    err_calc;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sum_clamp;
  logic                       sum_hit;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic signed [MUL_P_W-1:0]  mul_p;
  logic [EXT_W-1:0]           rapid_ext;
  logic [PWM_BITS-1:0]        rapid_sat;
  logic [EXT_W-1:0]           duty_ext;
  logic                       rem_ge;

  // Interval since the last sample; the default period stands in while no
  // timestamp is stored.
  assign dt_raw  = stamp - last_time;
  assign dt_calc = (last_time == '0) ? default_period_ms :
                   ((|dt_raw[TIME_W-1:DT_W]) ? DT_MAX : dt_raw[DT_W-1:0]);
  assign err_calc = ERR_W'(target_temp) - ERR_W'(meas);
  assign diff     = DIFF_W'(err) - DIFF_W'(last_error);

  always_comb begin
    sum       = SUM_W'(integral_sum) + $signed(prod[SUM_W-1:0]);
    sum_clamp = sum;
    sum_hit   = 1'b0;
    if (sum > INTEG_LIMIT) begin
      sum_clamp = INTEG_LIMIT;
      sum_hit   = 1'b1;
    end else if (sum < INTEG_FLOOR) begin
      sum_clamp = INTEG_FLOOR;
      sum_hit   = 1'b1;
    end
  end

  always_comb begin
    case (op)
      DP_ED: begin
        mul_a = MUL_A_W'(err);
        mul_b = MUL_B_W'(dt);
      end
      DP_ID: begin
        mul_a = MUL_A_W'(integral_sum);
        mul_b = MUL_B_W'(dt);
      end
      DP_IG: begin
        mul_a = $signed(prod[MUL_A_W-1:0]);
        mul_b = MUL_B_W'(gain_i);
      end
      DP_PE: begin
        mul_a = MUL_A_W'(err);
        mul_b = MUL_B_W'(gain_p);
      end
      DP_PK: begin
        mul_a = $signed(prod[MUL_A_W-1:0]);
        mul_b = SCALE_K;
      end
      DP_PD: begin
        mul_a = $signed(prod[MUL_A_W-1:0]);
        mul_b = MUL_B_W'(dt);
      end
      DP_DE: begin
        mul_a = MUL_A_W'(diff);
        mul_b = MUL_B_W'(gain_d);
      end
      DP_DK: begin
        mul_a = $signed(prod[MUL_A_W-1:0]);
        mul_b = SCALE_M;
      end
      DP_DEN: begin
        mul_a = DUTY_DENOM;
        mul_b = MUL_B_W'(dt);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  assign rapid_ext = EXT_W'(rapid_duty);
  assign rapid_sat = (rapid_ext > EXT_W'(MX)) ? MX : rapid_ext[PWM_BITS-1:0];
  assign duty_ext  = EXT_W'(duty_level);
  assign rem_ge    = (rem >= dvs);

  assign stat.enable     = enable;
  assign stat.dt_zero    = (dt == '0);
  assign stat.rapid      = DIFF_W'(err) > $signed({3'b000, handoff_band});
  assign stat.acc_nonpos = (acc <= 0);
  assign stat.acc_ge_den = (acc >= prod);

  // Registers with reset: configuration and the controller's own state.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_temp       <= '0;
      enable            <= 1'b0;
      gain_p            <= '0;
      gain_i            <= '0;
      gain_d            <= '0;
      handoff_band      <= '0;
      rapid_duty        <= '0;
      default_period_ms <= PERIOD_RST;
      integral_sum      <= '0;
      last_error        <= '0;
      last_time         <= '0;
      duty_level        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_TARGET_TEMP: target_temp <= $signed(cfg_data[TEMP_W-1:0]);
          REG_ENABLE: begin
            enable <= cfg_data[0];
            if (!cfg_data[0]) begin
              integral_sum <= '0;
              last_error   <= '0;
              duty_level   <= '0;
            end
          end
          REG_GAIN_P:     gain_p            <= cfg_data[GAIN_W-1:0];
          REG_GAIN_I:     gain_i            <= cfg_data[GAIN_W-1:0];
          REG_GAIN_D:     gain_d            <= cfg_data[GAIN_W-1:0];
          REG_BAND:       handoff_band      <= cfg_data[BAND_W-1:0];
          REG_RAPID_DUTY: rapid_duty        <= cfg_data[DUTY_W-1:0];
          REG_PERIOD:     default_period_ms <= cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end
      case (op)
        DP_PREP: last_time <= stamp;
        DP_RAPID: begin
          integral_sum <= '0;
          last_error   <= err;
          duty_level   <= rapid_sat;
        end
        DP_INTEG: integral_sum <= sum_clamp[INTEG_W-1:0];
        DP_DE:    last_error   <= err;
        DP_CHECK: begin
          if (stat.acc_nonpos) begin
            duty_level <= '0;
          end else if (stat.acc_ge_den) begin
            duty_level <= MX;
          end
        end
        DP_DIVEND: duty_level <= quo;
        default: ;
      endcase
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk) begin
    case (op)
      DP_CAPTURE: begin
        meas  <= $signed(measured_temp);
        stamp <= time_ms;
      end
      DP_PREP: begin
        dt  <= dt_calc;
        err <= err_calc;
      end
      DP_RAPID: begin
        rapid <= 1'b1;
        lim   <= 1'b0;
      end
      DP_ED: begin
        prod  <= mul_p[WIDE_W-1:0];
        rapid <= 1'b0;
      end
      DP_INTEG: lim <= sum_hit;
      DP_ID, DP_IG, DP_PK, DP_PD, DP_DK: prod <= mul_p[WIDE_W-1:0];
      DP_PE: begin
        acc  <= prod;
        prod <= mul_p[WIDE_W-1:0];
      end
      DP_DE, DP_DEN: begin
        acc  <= acc + prod;
        prod <= mul_p[WIDE_W-1:0];
      end
      DP_CHECK: begin
        // Numerator times the full-scale count, then long division by the
        // denominator one quotient bit per cycle.
        rem <= WIDE_W'(acc <<< PWM_BITS) - WIDE_W'(acc);
        dvs <= WIDE_W'(prod) << (PWM_BITS - 1);
        quo <= '0;
      end
      DP_DIV: begin
        if (rem_ge) begin
          rem <= rem - dvs;
        end
        quo <= {quo[PWM_BITS-2:0], rem_ge};
        dvs <= dvs >> 1;
      end
      DP_OUT: begin
        duty             <= duty_ext[DUTY_W-1:0];
        rapid_mode       <= rapid;
        integral_limited <= lim;
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/hpid_ctrl.sv @@
// Sequencing state machine of the heater PID controller.
module hpid_ctrl import hpid_pkg::*; #(
  parameter int PWM_BITS = PWM_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  localparam int CNT_W = $clog2(PWM_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PWM_BITS - 1);

  ctrl_state_t      state;
  ctrl_state_t      state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             slot_free;
  logic             out_load;

  assign slot_free = !out_valid || out_ready;
  assign cnt_next  = (state == ST_DIV) ? cnt + 1'b1 : '0;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid && stat.enable) state_next = ST_PREP;
      ST_PREP:   state_next = ST_EVAL;
      ST_EVAL: begin
        if (stat.dt_zero) begin
          state_next = ST_IDLE;
        end else if (stat.rapid) begin
          state_next = ST_RAPID;
        end else begin
          state_next = ST_ED;
        end
      end
      ST_RAPID:  state_next = ST_OUT;
      ST_ED:     state_next = ST_INTEG;
      ST_INTEG:  state_next = ST_ID;
      ST_ID:     state_next = ST_IG;
      ST_IG:     state_next = ST_PE;
      ST_PE:     state_next = ST_PK;
      ST_PK:     state_next = ST_PD;
      ST_PD:     state_next = ST_DE;
      ST_DE:     state_next = ST_DK;
      ST_DK:     state_next = ST_DEN;
      ST_DEN:    state_next = ST_CHECK;
      ST_CHECK: begin
        if (stat.acc_nonpos || stat.acc_ge_den) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV:    if (cnt == CNT_LAST) state_next = ST_DIVEND;
      ST_DIVEND: state_next = ST_OUT;
      ST_OUT:    if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    op       = DP_NOP;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = DP_CAPTURE;
      end
      ST_PREP:   op = DP_PREP;
      ST_RAPID:  op = DP_RAPID;
      ST_ED:     op = DP_ED;
      ST_INTEG:  op = DP_INTEG;
      ST_ID:     op = DP_ID;
      ST_IG:     op = DP_IG;
      ST_PE:     op = DP_PE;
      ST_PK:     op = DP_PK;
      ST_PD:     op = DP_PD;
      ST_DE:     op = DP_DE;
      ST_DK:     op = DP_DK;
      ST_DEN:    op = DP_DEN;
      ST_CHECK:  op = DP_CHECK;
      ST_DIV:    op = DP_DIV;
      ST_DIVEND: op = DP_DIVEND;
      ST_OUT: begin
        if (slot_free) begin
          op       = DP_OUT;
          out_load = 1'b1;
        end
      end
      default:   op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/hpid_checker.sv @@
// Port-level checker for the heater PID controller, bound to the top level.
`include "heater_pid_with_rapid_heat_defines.svh"

module hpid_checker import hpid_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DUTY_W-1:0] duty,
  input logic              rapid_mode,
  input logic              integral_limited
);

  // A stalled output word holds.
  `HPID_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(duty) && $stable(rapid_mode) && $stable(integral_limited))

  // Rapid-heat words never report the integral clamp.
  `HPID_ASSERT_IMP(a_flags_exclusive, clk, rst, out_valid, !(rapid_mode && integral_limited))

  // A new result only appears after a busy cycle, never straight from idle.
  `HPID_ASSERT_IMP(a_result_after_work, clk, rst, $rose(out_valid), !$past(in_ready))

endmodule

bind heater_pid_with_rapid_heat hpid_checker u_hpid_checker (.*);
